FILE: hdl/fpa_pkg.sv
// Package with the types, constants and register indexes of the footstep peak averager.
package fpa_pkg;

    localparam int NUM_CH    = 5;
    localparam int CH_W      = 3;
    localparam int SAMPLE_W  = 10;
    localparam int SUM_W     = 16;
    localparam int CONTACT_W = 8;
    localparam int STEPS_W   = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 10;
    localparam int FRONT_CH  = 3;
    localparam int DIV_CNT_W = 4;

    localparam logic [CONTACT_W-1:0] CONTACT_MAX   = 8'd255;
    localparam logic [SAMPLE_W-1:0]  FRONT_THR_RST = 10'd15;
    localparam logic [SAMPLE_W-1:0]  REAR_THR_RST  = 10'd10;
    localparam logic [CONTACT_W-1:0] MIN_CONT_RST  = 8'd2;
    localparam logic [STEPS_W-1:0]   STEPS_RPT_RST = 6'd10;

    localparam logic [CFG_IDX_W-1:0] REG_FRONT_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REAR_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CONT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_RPT = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        ACT_PEAK,
        ACT_CLEAR,
        ACT_RECORD
    } t_action;

    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   dividend;
        logic [STEPS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: hdl/fpa_in_if.sv
// Interface of the input channel that carries one frame of five pressure samples.
interface fpa_in_if;
    logic                          valid;
    logic                          ready;
    logic [fpa_pkg::SAMPLE_W-1:0]  sample0;
    logic [fpa_pkg::SAMPLE_W-1:0]  sample1;
    logic [fpa_pkg::SAMPLE_W-1:0]  sample2;
    logic [fpa_pkg::SAMPLE_W-1:0]  sample3;
    logic [fpa_pkg::SAMPLE_W-1:0]  sample4;

    modport source (output valid, output sample0, output sample1, output sample2,
                    output sample3, output sample4, input ready);
    modport sink   (input valid, input sample0, input sample1, input sample2,
                    input sample3, input sample4, output ready);
endinterface

FILE: hdl/fpa_out_if.sv
// Interface of the output channel that carries the five averaged step peaks.
interface fpa_out_if;
    logic                          valid;
    logic                          ready;
    logic [fpa_pkg::SAMPLE_W-1:0]  avg0;
    logic [fpa_pkg::SAMPLE_W-1:0]  avg1;
    logic [fpa_pkg::SAMPLE_W-1:0]  avg2;
    logic [fpa_pkg::SAMPLE_W-1:0]  avg3;
    logic [fpa_pkg::SAMPLE_W-1:0]  avg4;

    modport source (output valid, output avg0, output avg1, output avg2,
                    output avg3, output avg4, input ready);
    modport sink   (input valid, input avg0, input avg1, input avg2,
                    input avg3, input avg4, output ready);
endinterface

FILE: hdl/fpa_cfg_if.sv
// Interface of the configuration write channel.
interface fpa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fpa_pkg::CFG_IDX_W-1:0]  index;
    logic [fpa_pkg::CFG_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/fpa_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module fpa_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fpa_pkg::t_div_req   i_req,
    output fpa_pkg::t_div_rsp   o_rsp
);

    logic                              r_busy;
    logic                              r_done;
    logic [fpa_pkg::DIV_CNT_W-1:0]     r_count;
    logic [fpa_pkg::SUM_W-1:0]         r_quo;
    logic [fpa_pkg::STEPS_W-1:0]       r_rem;
    logic [fpa_pkg::STEPS_W-1:0]       r_divisor;
    logic [fpa_pkg::STEPS_W:0]         shifted;
    logic [fpa_pkg::STEPS_W:0]         diff;
    logic                              ge;

    assign shifted = {r_rem, r_quo[fpa_pkg::SUM_W-1]};
    assign ge      = shifted >= {1'b0, r_divisor};
    assign diff    = shifted - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_count == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_count == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo     <= i_req.dividend;
            r_rem     <= '0;
            r_divisor <= i_req.divisor;
            r_count   <= '1;
        end else if (r_busy) begin
            r_rem   <= ge ? diff[fpa_pkg::STEPS_W-1:0] : shifted[fpa_pkg::STEPS_W-1:0];
            r_quo   <= {r_quo[fpa_pkg::SUM_W-2:0], ge};
            r_count <= r_count - 1'b1;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: hdl/footstep_peak_averager_core.sv
// Top level of the footstep peak averager: step detection, peak tracking and averaging.
//
//  channel  | role   | payload                          | ready
//  i_in     | sink   | sample0..sample4, 10 bits each   | high only in the idle state
//  o_out    | source | avg0..avg4, 10 bits each         | held in an output register
//  i_cfg    | sink   | index 2 bits, data 10 bits       | always high
//
// A frame goes from the idle state through the shared comparator: five threshold compares,
// one decision, five peak or sum updates and one report check.
// A frame that completes a report then runs the bit-serial divider once per channel and
// loads the output register, waiting first if the previous report is unread.
// Reset is synchronous, clears the counters, peaks, sums and output valid flag, and loads
// the configuration registers with their defaults.
module footstep_peak_averager_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpa_in_if.sink    i_in,
    fpa_out_if.source o_out,
    fpa_cfg_if.sink   i_cfg
);

    fpa_pkg::t_state                   r_state, n_state;
    fpa_pkg::t_action                  r_action, n_action;
    logic [fpa_pkg::CH_W-1:0]          r_ch, n_ch;
    logic                              r_idle, n_idle;
    logic [fpa_pkg::CONTACT_W-1:0]     r_contact, n_contact;
    logic [fpa_pkg::STEPS_W-1:0]       r_steps, n_steps;
    logic [fpa_pkg::SAMPLE_W-1:0]      r_smp  [fpa_pkg::NUM_CH];
    logic [fpa_pkg::SAMPLE_W-1:0]      r_peak [fpa_pkg::NUM_CH];
    logic [fpa_pkg::SAMPLE_W-1:0]      n_peak [fpa_pkg::NUM_CH];
    logic [fpa_pkg::SUM_W-1:0]         r_sum  [fpa_pkg::NUM_CH];
    logic [fpa_pkg::SUM_W-1:0]         n_sum  [fpa_pkg::NUM_CH];
    logic [fpa_pkg::SAMPLE_W-1:0]      r_avg  [fpa_pkg::NUM_CH];
    logic [fpa_pkg::SAMPLE_W-1:0]      n_avg  [fpa_pkg::NUM_CH];
    logic [fpa_pkg::SAMPLE_W-1:0]      r_out  [fpa_pkg::NUM_CH];
    logic                              r_out_valid, n_out_valid;
    logic                              load_out;

    logic [fpa_pkg::SAMPLE_W-1:0]      r_front_thr;
    logic [fpa_pkg::SAMPLE_W-1:0]      r_rear_thr;
    logic [fpa_pkg::CONTACT_W-1:0]     r_min_cont;
    logic [fpa_pkg::STEPS_W-1:0]       r_steps_rpt;
    logic [fpa_pkg::STEPS_W-1:0]       limit;

    logic [fpa_pkg::SAMPLE_W-1:0]      cmp_a;
    logic [fpa_pkg::SAMPLE_W-1:0]      cmp_b;
    logic                              cmp_lt;

    logic                              in_acc;
    logic                              last_ch;
    fpa_pkg::t_div_req                 div_req;
    fpa_pkg::t_div_rsp                 div_rsp;

    assign in_acc  = i_in.valid && i_in.ready;
    assign last_ch = r_ch == fpa_pkg::CH_W'(fpa_pkg::NUM_CH - 1);
    assign limit   = (r_steps_rpt == '0) ? fpa_pkg::STEPS_W'(1) : r_steps_rpt;
    assign cmp_lt  = cmp_a < cmp_b;

    assign i_in.ready  = r_state == fpa_pkg::ST_IDLE;
    assign i_cfg.ready = 1'b1;

    fpa_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_thr <= fpa_pkg::FRONT_THR_RST;
            r_rear_thr  <= fpa_pkg::REAR_THR_RST;
            r_min_cont  <= fpa_pkg::MIN_CONT_RST;
            r_steps_rpt <= fpa_pkg::STEPS_RPT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                fpa_pkg::REG_FRONT_THR: r_front_thr <= i_cfg.data;
                fpa_pkg::REG_REAR_THR:  r_rear_thr  <= i_cfg.data;
                fpa_pkg::REG_MIN_CONT:  r_min_cont  <= i_cfg.data[fpa_pkg::CONTACT_W-1:0];
                fpa_pkg::REG_STEPS_RPT: r_steps_rpt <= i_cfg.data[fpa_pkg::STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpa_pkg::ST_IDLE;
            r_action    <= fpa_pkg::ACT_PEAK;
            r_ch        <= '0;
            r_idle      <= 1'b0;
            r_contact   <= '0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < fpa_pkg::NUM_CH; i++) begin
                r_peak[i] <= '0;
                r_sum[i]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_action    <= n_action;
            r_ch        <= n_ch;
            r_idle      <= n_idle;
            r_contact   <= n_contact;
            r_steps     <= n_steps;
            r_out_valid <= n_out_valid;
            for (int i = 0; i < fpa_pkg::NUM_CH; i++) begin
                r_peak[i] <= n_peak[i];
                r_sum[i]  <= n_sum[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_smp[0] <= i_in.sample0;
            r_smp[1] <= i_in.sample1;
            r_smp[2] <= i_in.sample2;
            r_smp[3] <= i_in.sample3;
            r_smp[4] <= i_in.sample4;
        end
        for (int i = 0; i < fpa_pkg::NUM_CH; i++) begin
            r_avg[i] <= n_avg[i];
            if (load_out) begin
                r_out[i] <= r_avg[i];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_ch        = r_ch;
        n_idle      = r_idle;
        n_contact   = r_contact;
        n_steps     = r_steps;
        n_out_valid = r_out_valid && !o_out.ready;
        load_out    = 1'b0;
        cmp_a       = '0;
        cmp_b       = '0;
        div_req     = '0;
        for (int i = 0; i < fpa_pkg::NUM_CH; i++) begin
            n_peak[i] = r_peak[i];
            n_sum[i]  = r_sum[i];
            n_avg[i]  = r_avg[i];
        end

        case (r_state)
            fpa_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = fpa_pkg::ST_SCAN;
                    n_ch    = '0;
                    n_idle  = 1'b1;
                end
            end

            fpa_pkg::ST_SCAN: begin
                cmp_a  = r_smp[r_ch];
                cmp_b  = (r_ch < fpa_pkg::CH_W'(fpa_pkg::FRONT_CH)) ? r_front_thr : r_rear_thr;
                n_idle = r_idle && cmp_lt;
                if (last_ch) begin
                    n_state = fpa_pkg::ST_DECIDE;
                    n_ch    = '0;
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end

            fpa_pkg::ST_DECIDE: begin
                cmp_a   = {2'b00, r_contact};
                cmp_b   = {2'b00, r_min_cont};
                n_state = fpa_pkg::ST_UPDATE;
                if (!r_idle) begin
                    n_action = fpa_pkg::ACT_PEAK;
                    if (r_contact != fpa_pkg::CONTACT_MAX) begin
                        n_contact = r_contact + 1'b1;
                    end
                end else if (cmp_lt) begin
                    n_action  = fpa_pkg::ACT_CLEAR;
                    n_contact = '0;
                end else begin
                    n_action  = fpa_pkg::ACT_RECORD;
                    n_contact = '0;
                    n_steps   = r_steps + 1'b1;
                end
            end

            fpa_pkg::ST_UPDATE: begin
                cmp_a = r_peak[r_ch];
                cmp_b = r_smp[r_ch];
                case (r_action)
                    fpa_pkg::ACT_PEAK: begin
                        if (cmp_lt) begin
                            n_peak[r_ch] = r_smp[r_ch];
                        end
                    end
                    fpa_pkg::ACT_RECORD: begin
                        n_sum[r_ch]  = r_sum[r_ch] + fpa_pkg::SUM_W'(r_peak[r_ch]);
                        n_peak[r_ch] = '0;
                    end
                    default: begin
                        n_peak[r_ch] = '0;
                    end
                endcase
                if (last_ch) begin
                    n_state = fpa_pkg::ST_CHECK;
                    n_ch    = '0;
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end

            fpa_pkg::ST_CHECK: begin
                cmp_a = {4'b0000, r_steps};
                cmp_b = {4'b0000, limit};
                n_ch  = '0;
                if (cmp_lt) begin
                    n_state = fpa_pkg::ST_IDLE;
                end else begin
                    n_state = fpa_pkg::ST_DIV_START;
                end
            end

            fpa_pkg::ST_DIV_START: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_sum[r_ch];
                div_req.divisor  = r_steps;
                n_state          = fpa_pkg::ST_DIV_WAIT;
            end

            fpa_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_avg[r_ch] = div_rsp.quotient[fpa_pkg::SAMPLE_W-1:0];
                    n_sum[r_ch] = '0;
                    if (last_ch) begin
                        n_state = fpa_pkg::ST_EMIT;
                        n_ch    = '0;
                    end else begin
                        n_state = fpa_pkg::ST_DIV_START;
                        n_ch    = r_ch + 1'b1;
                    end
                end
            end

            fpa_pkg::ST_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_steps     = '0;
                    n_state     = fpa_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = fpa_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out.valid = r_out_valid;
    assign o_out.avg0  = r_out[0];
    assign o_out.avg1  = r_out[1];
    assign o_out.avg2  = r_out[2];
    assign o_out.avg3  = r_out[3];
    assign o_out.avg4  = r_out[4];

endmodule
